>>> hdl/capsb_pkg.sv
// ----------------------------------------------------------------------------
// capsb_pkg
// Shared constants, types and the resource table of the cache pipe
// admission scoreboard.
// ----------------------------------------------------------------------------
package capsb_pkg;

  localparam int PIPE_DEPTH = 8;
  localparam int SET_BITS   = 12;
  localparam int TAG_BITS   = 8;
  localparam int STAGE_BITS = $clog2(PIPE_DEPTH);

  // stages searched for a pending grant; the latest one wins
  localparam int GRANT_HI = 4;
  localparam int GRANT_LO = 2;

  // request kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // task sources
  localparam logic [2:0] SRC_NONE     = 3'd0;
  localparam logic [2:0] SRC_L2_ACQ   = 3'd1;
  localparam logic [2:0] SRC_L2_WB    = 3'd2;
  localparam logic [2:0] SRC_L3_GRANT = 3'd3;
  localparam logic [2:0] SRC_L3_REL   = 3'd4;
  localparam logic [2:0] SRC_PREFETCH = 3'd5;

  // resource mask bit positions
  localparam int RES_DIR_RD  = 0;
  localparam int RES_DIR_WR  = 1;
  localparam int RES_DATA_RD = 2;
  localparam int RES_DATA_WR = 3;
  localparam int RES_GRANT   = 4;

  // configuration register indexes
  localparam logic CFG_DIR_WRITE_STAGE = 1'b0;
  localparam logic CFG_DIR_READ_BYPASS = 1'b1;

  typedef logic [4:0] res_t;

  typedef struct packed {
    logic [2:0]          source;
    res_t                res;
    logic [SET_BITS-1:0] set_index;
    logic [TAG_BITS-1:0] tag;
  } stage_t;

  typedef stage_t [PIPE_DEPTH-1:0] stage_vec_t;

  typedef struct packed {
    logic ok;
    res_t res;
    logic set_conflict;
    logic data_stall;
    logic dir_stall;
  } decision_t;

  typedef struct packed {
    logic                  valid;
    logic [STAGE_BITS-1:0] stage;
    logic [TAG_BITS-1:0]   tag;
  } grant_t;

  function automatic res_t base_res(input logic [2:0] src);
    res_t r;
    r = '0;
    case (src)
      SRC_L2_ACQ:   r[RES_DIR_RD] = 1'b1;
      SRC_L2_WB: begin
        r[RES_DIR_RD]  = 1'b1;
        r[RES_DIR_WR]  = 1'b1;
        r[RES_DATA_WR] = 1'b1;
        r[RES_GRANT]   = 1'b1;
      end
      SRC_L3_GRANT: begin
        r[RES_DIR_RD]  = 1'b1;
        r[RES_DATA_RD] = 1'b1;
        r[RES_GRANT]   = 1'b1;
      end
      SRC_L3_REL:   r[RES_DATA_WR] = 1'b1;
      SRC_PREFETCH: r[RES_DIR_RD] = 1'b1;
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/capsb_decide.sv
// ----------------------------------------------------------------------------
// capsb_decide
// Admission checks for one request and grant selection for one tick,
// evaluated against the current stage contents.
// ----------------------------------------------------------------------------
module capsb_decide import capsb_pkg::*; (
  input  stage_vec_t          stages,
  input  logic [2:0]          dir_write_stage,
  input  logic                dir_read_bypass,
  input  logic [2:0]          source,
  input  logic [SET_BITS-1:0] set_index,
  input  logic                hit,
  input  logic                upgrade,
  output decision_t           decision,
  output grant_t              grant
);

  logic [STAGE_BITS-1:0] ws;
  logic                  is_acq;
  logic                  src_known;
  logic                  set_block;
  res_t                  res;
  logic                  data_stall;
  logic                  dir_stall;

  // clamp the write stage into the pipe
  always_comb begin
    if (int'(dir_write_stage) >= PIPE_DEPTH) begin
      ws = STAGE_BITS'(PIPE_DEPTH - 1);
    end else begin
      ws = STAGE_BITS'(dir_write_stage);
    end
  end

  assign is_acq    = (source == SRC_L2_ACQ);
  assign src_known = (source != SRC_NONE) && (int'(source) <= int'(SRC_PREFETCH));

  always_comb begin
    res       = base_res(source);
    set_block = 1'b0;
    if (is_acq && hit) begin
      res[RES_DIR_WR] = 1'b1;
      if (!upgrade) begin
        res[RES_DATA_RD] = 1'b1;
      end
    end
    if (is_acq) begin
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        if ((s <= int'(ws)) && (stages[s].source != SRC_NONE) &&
            (stages[s].set_index == set_index)) begin
          set_block = 1'b1;
        end
      end
    end
    if (dir_read_bypass) begin
      if (is_acq && (stages[ws].set_index == set_index)) begin
        res[RES_DIR_RD] = 1'b0;
      end
      set_block = 1'b0;
    end
  end

  assign data_stall = (res[RES_DATA_RD] || res[RES_DATA_WR]) &&
                      (stages[1].res[RES_DATA_RD] || stages[1].res[RES_DATA_WR]);
  assign dir_stall  = res[RES_DIR_RD] && stages[ws].res[RES_DIR_WR];

  always_comb begin
    decision.ok           = src_known && (stages[0].source == SRC_NONE) &&
                            !set_block && !data_stall && !dir_stall;
    decision.res          = res;
    decision.set_conflict = is_acq && set_block;
    decision.data_stall   = is_acq && data_stall;
    decision.dir_stall    = is_acq && dir_stall;
  end

  // latest stage wins, so scan upward and let later hits override
  always_comb begin
    grant = '0;
    for (int i = GRANT_LO; i <= GRANT_HI; i++) begin
      if ((stages[i].source == SRC_L3_GRANT) && stages[i].res[RES_GRANT]) begin
        grant.valid = 1'b1;
        grant.stage = STAGE_BITS'(i);
        grant.tag   = stages[i].tag;
      end
    end
  end

endmodule

>>> hdl/cache_pipe_admission_scoreboard_unit.sv
// ----------------------------------------------------------------------------
// cache_pipe_admission_scoreboard_unit
// Admission scoreboard for the main pipeline of a last-level cache slice.
// ----------------------------------------------------------------------------
// The block tracks the tasks in each stage of the cache main pipeline (source,
// set, tag and a mask of directory read/write, data read/write and grant
// buffer use). A tick request sends at most one grant, from the latest of
// stages 4..2 holding an L3 grant task that still owns the grant buffer, then
// advances every stage by one. An admission request is checked for stage 0
// busy, back-to-back data use, directory read against the write stage's
// directory write and (for L2 acquires without bypass) a set conflict up to
// the write stage; if clear it enters stage 0. One request is taken per clock
// while the result register is free or draining; each is registered in the
// request register, then its result in the result register. The rate is one
// per cycle, set by the single update of the stage registers by each request.
// Configuration may only be written while no request is in flight.
// ----------------------------------------------------------------------------
module cache_pipe_admission_scoreboard_unit import capsb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_write_en,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_data,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [2:0]          source,
  input  logic [SET_BITS-1:0] set_index,
  input  logic                hit,
  input  logic                upgrade,
  input  logic [TAG_BITS-1:0] tag,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                accepted,
  output logic                grant_valid,
  output logic [TAG_BITS-1:0] grant_tag,
  output logic [2:0]          grant_stage,
  output logic                set_conflict,
  output logic                data_stall,
  output logic                dir_stall
);

  // configuration registers
  logic [2:0] dir_write_stage;
  logic       dir_read_bypass;

  // request register
  logic                req_valid;
  logic                req_kind;
  logic [2:0]          req_source;
  logic [SET_BITS-1:0] req_set_index;
  logic                req_hit;
  logic                req_upgrade;
  logic [TAG_BITS-1:0] req_tag;

  // scoreboard
  stage_vec_t stages;
  stage_vec_t stages_next;

  decision_t decision;
  grant_t    grant;
  logic      advance;

  // request register moves on when the result register is free or draining
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_write_stage <= 3'd2;
      dir_read_bypass <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_DIR_WRITE_STAGE: dir_write_stage <= cfg_data;
        CFG_DIR_READ_BYPASS: dir_read_bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind      <= kind;
      req_source    <= source;
      req_set_index <= set_index;
      req_hit       <= hit;
      req_upgrade   <= upgrade;
      req_tag       <= tag;
    end
  end

  capsb_decide u_decide (
    .stages          (stages),
    .dir_write_stage (dir_write_stage),
    .dir_read_bypass (dir_read_bypass),
    .source          (req_source),
    .set_index       (req_set_index),
    .hit             (req_hit),
    .upgrade         (req_upgrade),
    .decision        (decision),
    .grant           (grant)
  );

  // next scoreboard contents
  always_comb begin
    stage_vec_t granted;
    granted     = stages;
    stages_next = stages;
    if (advance) begin
      if (req_kind == KIND_TICK) begin
        // drop the grant buffer of the stage that sent, then shift
        if (grant.valid) begin
          granted[grant.stage].res[RES_GRANT] = 1'b0;
        end
        for (int i = PIPE_DEPTH - 1; i > 0; i--) begin
          stages_next[i] = granted[i-1];
        end
        stages_next[0] = '0;
      end else if (decision.ok) begin
        stages_next[0].source    = req_source;
        stages_next[0].res       = stages[0].res | decision.res;
        stages_next[0].set_index = req_set_index;
        stages_next[0].tag       = req_tag;
      end
    end
  end

  // empty stages must read as set 0, so the whole scoreboard resets
  always_ff @(posedge clk) begin
    if (rst) begin
      stages <= '0;
    end else begin
      stages <= stages_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register; unused fields of each request kind read as zero
  always_ff @(posedge clk) begin
    if (advance) begin
      if (req_kind == KIND_TICK) begin
        accepted     <= 1'b0;
        grant_valid  <= grant.valid;
        grant_tag    <= grant.valid ? grant.tag : '0;
        grant_stage  <= grant.valid ? 3'(grant.stage) : 3'd0;
        set_conflict <= 1'b0;
        data_stall   <= 1'b0;
        dir_stall    <= 1'b0;
      end else begin
        accepted     <= decision.ok;
        grant_valid  <= 1'b0;
        grant_tag    <= '0;
        grant_stage  <= 3'd0;
        set_conflict <= decision.set_conflict;
        data_stall   <= decision.data_stall;
        dir_stall    <= decision.dir_stall;
      end
    end
  end

endmodule

>>> bench/tb_cache_pipe_admission_scoreboard_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cache_pipe_admission_scoreboard_unit
// Self-checking bench for the cache pipe admission scoreboard: a directed
// opening, then random tick/request traffic over several write-stage and
// bypass settings, with every result checked against an in-bench scoreboard.
// ----------------------------------------------------------------------------
module tb_cache_pipe_admission_scoreboard_unit;
  import capsb_pkg::*;

  localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int PHASE_ITEMS  = 104;
  localparam int NUM_PHASES   = 12;
  localparam int DRAIN_CYCLES = 4;

  // one request on the input channel
  typedef struct packed {
    logic                kind;
    logic [2:0]          source;
    logic [SET_BITS-1:0] set_index;
    logic                hit;
    logic                upgrade;
    logic [TAG_BITS-1:0] tag;
  } req_t;

  // what the block reports for one request
  typedef struct packed {
    logic                accepted;
    logic                grant_valid;
    logic [TAG_BITS-1:0] grant_tag;
    logic [2:0]          grant_stage;
    logic                set_conflict;
    logic                data_stall;
    logic                dir_stall;
  } verdict_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic                cfg_write_en = 1'b0;
  logic                cfg_index    = CFG_DIR_WRITE_STAGE;
  logic [2:0]          cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                kind         = KIND_TICK;
  logic [2:0]          source       = SRC_NONE;
  logic [SET_BITS-1:0] set_index    = '0;
  logic                hit          = 1'b0;
  logic                upgrade      = 1'b0;
  logic [TAG_BITS-1:0] tag          = '0;
  logic                out_ready    = 1'b0;

  // block outputs
  logic                in_ready;
  logic                out_valid;
  logic                accepted;
  logic                grant_valid;
  logic [TAG_BITS-1:0] grant_tag;
  logic [2:0]          grant_stage;
  logic                set_conflict;
  logic                data_stall;
  logic                dir_stall;

  cache_pipe_admission_scoreboard_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .source       (source),
    .set_index    (set_index),
    .hit          (hit),
    .upgrade      (upgrade),
    .tag          (tag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .grant_valid  (grant_valid),
    .grant_tag    (grant_tag),
    .grant_stage  (grant_stage),
    .set_conflict (set_conflict),
    .data_stall   (data_stall),
    .dir_stall    (dir_stall)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  req_t     pending_reqs[$];       // requests waiting to be driven
  verdict_t expected_verdicts[$];  // predicted results, oldest first
  req_t     drv_req;               // request currently on the input channel

  // shadow copy of the pipeline and of the two registers
  stage_t     shadow_pipe [PIPE_DEPTH] = '{default: '0};
  logic [2:0] shadow_wr_stage = 3'd2;
  logic       shadow_bypass   = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  logic        stuck         = 1'b0;

  // a few sets reused heavily so that set conflicts and bypass hits happen
  logic [SET_BITS-1:0] hot_sets [4];

  // --------------------------------------------------------------------------
  // scoreboard prediction: applies one request to the shadow pipeline
  // --------------------------------------------------------------------------
  function automatic verdict_t advance_pipeline(input req_t r);
    verdict_t v;
    res_t     need;
    int       ws;
    int       i;
    logic     set_hit;
    logic     busy_data;
    logic     dir_clash;
    v = '0;
    if (r.kind == KIND_TICK) begin
      // latest pending L3 grant in the grant window wins the grant buffer
      for (i = GRANT_HI; i >= GRANT_LO; i--) begin
        if (!v.grant_valid && shadow_pipe[i].source == SRC_L3_GRANT &&
            shadow_pipe[i].res[RES_GRANT]) begin
          shadow_pipe[i].res[RES_GRANT] = 1'b0;
          v.grant_valid = 1'b1;
          v.grant_tag   = shadow_pipe[i].tag;
          v.grant_stage = 3'(i);
        end
      end
      for (i = PIPE_DEPTH - 1; i > 0; i--)
        shadow_pipe[i] = shadow_pipe[i-1];
      shadow_pipe[0] = '0;
      return v;
    end

    // unknown sources are refused with no flags
    if (r.source == SRC_NONE || r.source > SRC_PREFETCH)
      return v;

    ws = (int'(shadow_wr_stage) >= PIPE_DEPTH) ? PIPE_DEPTH - 1 : int'(shadow_wr_stage);

    // resources the task will hold
    need = '0;
    case (r.source)
      SRC_L2_ACQ: begin
        need[RES_DIR_RD] = 1'b1;
        if (r.hit) begin
          need[RES_DIR_WR]  = 1'b1;
          need[RES_DATA_RD] = !r.upgrade;
        end
      end
      SRC_L2_WB: begin
        need[RES_DIR_RD]  = 1'b1;
        need[RES_DIR_WR]  = 1'b1;
        need[RES_DATA_WR] = 1'b1;
        need[RES_GRANT]   = 1'b1;
      end
      SRC_L3_GRANT: begin
        need[RES_DIR_RD]  = 1'b1;
        need[RES_DATA_RD] = 1'b1;
        need[RES_GRANT]   = 1'b1;
      end
      SRC_L3_REL:   need[RES_DATA_WR] = 1'b1;
      default:      need[RES_DIR_RD]  = 1'b1;  // prefetch
    endcase

    // same-set task between stage 1 and the write stage
    set_hit = 1'b0;
    if (r.source == SRC_L2_ACQ) begin
      for (i = 1; i <= ws; i++) begin
        if (shadow_pipe[i].source != SRC_NONE && shadow_pipe[i].set_index == r.set_index)
          set_hit = 1'b1;
      end
    end

    // bypass: no set blocking, and an acquire to the write stage's set skips the
    // directory read (an empty stage compares as set 0)
    if (shadow_bypass) begin
      if (r.source == SRC_L2_ACQ && shadow_pipe[ws].set_index == r.set_index)
        need[RES_DIR_RD] = 1'b0;
      set_hit = 1'b0;
    end

    busy_data = (need[RES_DATA_RD] || need[RES_DATA_WR]) &&
                (shadow_pipe[1].res[RES_DATA_RD] || shadow_pipe[1].res[RES_DATA_WR]);
    dir_clash = need[RES_DIR_RD] && shadow_pipe[ws].res[RES_DIR_WR];

    if (r.source == SRC_L2_ACQ) begin
      v.set_conflict = set_hit;
      v.data_stall   = busy_data;
      v.dir_stall    = dir_clash;
    end

    if (shadow_pipe[0].source == SRC_NONE && !set_hit && !busy_data && !dir_clash) begin
      shadow_pipe[0].source    = r.source;
      shadow_pipe[0].res       = need;
      shadow_pipe[0].set_index = r.set_index;
      shadow_pipe[0].tag       = r.tag;
      v.accepted = 1'b1;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic req_t make_req(input logic k, input logic [2:0] src,
                                    input logic [SET_BITS-1:0] s, input logic h,
                                    input logic u, input logic [TAG_BITS-1:0] t);
    req_t r;
    r = '{kind: k, source: src, set_index: s, hit: h, upgrade: u, tag: t};
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned roll;
    r.kind = ($urandom_range(99) < 40) ? KIND_TICK : KIND_REQUEST;
    roll = $urandom_range(99);
    if (roll < 35)
      r.source = SRC_L2_ACQ;
    else if (roll < 95)
      r.source = 3'($urandom_range(SRC_PREFETCH, SRC_L2_WB));
    else if (roll < 97)
      r.source = SRC_NONE;
    else
      r.source = SRC_PREFETCH + 3'($urandom_range(2, 1));  // codes past the last source
    // mostly hot sets, sometimes anywhere in the range
    if ($urandom_range(99) < 70)
      r.set_index = hot_sets[$urandom_range(3)];
    else
      r.set_index = SET_BITS'($urandom());
    r.hit     = 1'($urandom_range(1));
    r.upgrade = 1'($urandom_range(1));
    r.tag     = TAG_BITS'($urandom());
    return r;
  endfunction

  // both registers back to back, only while the block is idle
  task automatic program_regs(input logic [2:0] wr_stage, input logic bypass);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_DIR_WRITE_STAGE;
    cfg_data     <= wr_stage;
    @(posedge clk);
    cfg_index    <= CFG_DIR_READ_BYPASS;
    cfg_data     <= {2'b00, bypass};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    shadow_wr_stage = wr_stage;
    shadow_bypass   = bypass;
  endtask

  // nothing queued, nothing on the wire, nothing outstanding; looked at on the
  // falling edge so that the driver and monitor updates of the rising edge have
  // all landed
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // driver: presents queued requests, holds each until it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // request taken at this edge: predict its result now
      if (in_valid && in_ready)
        expected_verdicts.push_back(advance_pipeline(drv_req));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          kind      <= drv_req.kind;
          source    <= drv_req.source;
          set_index <= drv_req.set_index;
          hit       <= drv_req.hit;
          upgrade   <= drv_req.upgrade;
          tag       <= drv_req.tag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks every result against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          check_field("accepted",     exp_v.accepted,     accepted);
          check_field("grant_valid",  exp_v.grant_valid,  grant_valid);
          check_field("grant_tag",    exp_v.grant_tag,    grant_tag);
          check_field("grant_stage",  exp_v.grant_stage,  grant_stage);
          check_field("set_conflict", exp_v.set_conflict, set_conflict);
          check_field("data_stall",   exp_v.data_stall,   data_stall);
          check_field("dir_stall",    exp_v.dir_stall,    dir_stall);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no handshake on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT)
        stuck <= 1'b1;
    end
  end

  initial begin
    wait (stuck);
    $error("no handshake for %0d cycles", QUIET_LIMIT);
    $display("tb_cache_pipe_admission_scoreboard_unit: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  // register settings per random phase, extremes of the write stage included
  logic [2:0] phase_wr_stage [NUM_PHASES] = '{3'd1, 3'd7, 3'd0, 3'd3, 3'd2, 3'd5,
                                              3'd7, 3'd1, 3'd4, 3'd6, 3'd0, 3'd2};
  logic       phase_bypass   [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                                              1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  initial begin
    int p;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // first third: sender rarely idles, receiver often stalls
    send_idle_pct = 10;
    recv_idle_pct = 68;

    // directed opening under the reset settings (write stage 2, no bypass)
    pending_reqs.push_back(make_req(KIND_TICK, SRC_NONE, '0, 1'b0, 1'b0, '0));
    // acquire miss into an empty pipe, then stage 0 busy
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L2_ACQ, '0, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_PREFETCH, '0, 1'b0, 1'b0, 8'h01));
    pending_reqs.push_back(make_req(KIND_TICK, SRC_NONE, '0, 1'b0, 1'b0, '0));
    // same set as stage 1: set conflict
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L2_ACQ, '0, 1'b1, 1'b0, 8'h02));
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L3_GRANT, '1, 1'b0, 1'b0, '1));
    pending_reqs.push_back(make_req(KIND_TICK, SRC_NONE, '0, 1'b0, 1'b0, '0));
    // data right behind a data user
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L2_ACQ, '1, 1'b1, 1'b0, 8'h03));
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L2_WB, 12'h00c, 1'b1, 1'b1, 8'h04));
    pending_reqs.push_back(make_req(KIND_TICK, SRC_NONE, '0, 1'b0, 1'b0, '0));
    // writeback reaching the write stage blocks directory reads
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L2_WB, 12'h0a5, 1'b0, 1'b0, 8'h05));
    pending_reqs.push_back(make_req(KIND_TICK, '1, '1, 1'b1, 1'b1, '1));
    pending_reqs.push_back(make_req(KIND_TICK, SRC_NONE, '0, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L2_ACQ, 12'h5a5, 1'b1, 1'b1, 8'h06));
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_L3_REL, '1, 1'b1, 1'b1, 8'haa));
    // unknown sources, with every other field at its extremes
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_NONE, '1, 1'b1, 1'b1, '1));
    pending_reqs.push_back(make_req(KIND_REQUEST, SRC_PREFETCH + 3'd1, '0, 1'b0, 1'b0, '0));
    pending_reqs.push_back(make_req(KIND_REQUEST, '1, '1, 1'b1, 1'b1, 8'h55));
    // tick the grant task through the grant window
    for (n = 0; n < 6; n++)
      pending_reqs.push_back(make_req(KIND_TICK, SRC_NONE, '0, 1'b0, 1'b0, '0));
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      program_regs(phase_wr_stage[p], phase_bypass[p]);
      // second third swaps the idling, last third runs flat out
      if (p == NUM_PHASES / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 10;
      end else if (p == 2 * NUM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      hot_sets[0] = '0;
      hot_sets[1] = '1;
      hot_sets[2] = SET_BITS'($urandom());
      hot_sets[3] = SET_BITS'($urandom());
      for (n = 0; n < PHASE_ITEMS; n++)
        pending_reqs.push_back(random_req());
      wait_idle();
    end

    if (mismatches == 0)
      $display("tb_cache_pipe_admission_scoreboard_unit: PASS");
    else
      $display("tb_cache_pipe_admission_scoreboard_unit: FAIL");
    $finish;
  end

endmodule
